[hdl/pcrg_pkg.sv]
// Shared types and constants for the pipe cell rectangle generator.
package pcrg_pkg;

  localparam int GRID_SIDE = 256;
  localparam int GRID_W = 11;

  typedef enum logic [2:0] {
    REG_BACKGROUND = 3'd0,
    REG_PIPE       = 3'd1,
    REG_GLOW       = 3'd2,
    REG_TILE_SIZE  = 3'd3,
    REG_ORIGIN_X   = 3'd4,
    REG_ORIGIN_Y   = 3'd5
  } reg_index_t;

  localparam logic [23:0] BACKGROUND_RESET = 24'h0A0E12;
  localparam logic [7:0]  TILE_SIZE_RESET  = 8'd16;

  localparam logic [7:0] PIPE_ALPHA      = 8'd208;
  localparam logic [7:0] HIGHLIGHT_ALPHA = 8'd120;
  localparam logic [7:0] GLOW_THRESHOLD  = 8'd32;
  localparam logic [7:0] THIRD_RECIP     = 8'd171;
  localparam logic [6:0] MIN_SIDE        = 7'd2;

  typedef logic signed [17:0] coord_t;

  typedef struct packed {
    logic [3:0]  mask;
    logic [7:0]  glow;
    logic [7:0]  alpha;
    logic [7:0]  cs;
    logic [6:0]  thick;
    logic [7:0]  arm;
    logic [6:0]  joint;
    logic [6:0]  inner;
    coord_t      left;
    coord_t      top;
    coord_t      mx;
    coord_t      my;
    coord_t      jx;
    coord_t      jy;
    coord_t      tx;
    coord_t      ty;
    coord_t      ix;
    coord_t      iy;
    logic [23:0] active;
  } cell_t;

endpackage

[hdl/pcrg_blend.sv]
// Two-stage per-channel color blend: multiply, then divide by 255 and add to or subtract from the base.
module pcrg_blend (
  input  logic        clk,
  input  logic        en_mul,
  input  logic        en_sum,
  input  logic [23:0] lhs,
  input  logic [23:0] rhs,
  input  logic [7:0]  alpha,
  output logic [23:0] rgb
);

  logic [7:0]  base_q [3];
  logic [2:0]  neg_q;
  logic [15:0] prod_q [3];

  always_ff @(posedge clk) begin
    if (en_mul) begin
      for (int c = 0; c < 3; c++) begin
        base_q[c] <= lhs[c*8 +: 8];
        neg_q[c]  <= rhs[c*8 +: 8] < lhs[c*8 +: 8];
        if (rhs[c*8 +: 8] < lhs[c*8 +: 8]) begin
          prod_q[c] <= {8'd0, lhs[c*8 +: 8] - rhs[c*8 +: 8]} * {8'd0, alpha};
        end else begin
          prod_q[c] <= {8'd0, rhs[c*8 +: 8] - lhs[c*8 +: 8]} * {8'd0, alpha};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0] sum;
    logic [7:0]  quot;
    if (en_sum) begin
      for (int c = 0; c < 3; c++) begin
        sum  = {1'b0, prod_q[c]} + {9'd0, prod_q[c][15:8]} + 17'd1;
        quot = sum[15:8];
        if (neg_q[c]) begin
          rgb[c*8 +: 8] <= base_q[c] - quot;
        end else begin
          rgb[c*8 +: 8] <= base_q[c] + quot;
        end
      end
    end
  end

endmodule

[hdl/pcrg_emit.sv]
// Output stage that issues the rectangles of one cell, one word per cycle while rect_ready is high.
module pcrg_emit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load_valid,
  output logic                   load_ready,
  input  pcrg_pkg::cell_t        load_data,
  input  logic [23:0]            hi_rgb,
  output logic                   rect_valid,
  input  logic                   rect_ready,
  output pcrg_pkg::coord_t       rect_x,
  output pcrg_pkg::coord_t       rect_y,
  output logic [7:0]             rect_width,
  output logic [7:0]             rect_height,
  output logic [23:0]            rect_rgb,
  output logic                   last_rect
);

  pcrg_pkg::cell_t cur;
  logic [23:0]     cur_hi;
  logic [5:0]      pend;
  logic [5:0]      pend_next;

  assign pend_next  = pend & (pend - 6'd1);
  assign rect_valid = |pend;
  assign last_rect  = pend_next == 6'd0;
  assign load_ready = !rect_valid || (rect_ready && last_rect);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load_valid && load_ready) begin
      pend <= {load_data.glow > pcrg_pkg::GLOW_THRESHOLD, load_data.mask,
               load_data.cs != 8'd0};
    end else if (rect_valid && rect_ready) begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      cur    <= load_data;
      cur_hi <= hi_rgb;
    end
  end

  always_comb begin
    rect_rgb = cur.active;
    if (pend[0]) begin
      rect_x      = cur.jx;
      rect_y      = cur.jy;
      rect_width  = {1'b0, cur.joint};
      rect_height = {1'b0, cur.joint};
    end else if (pend[1]) begin
      rect_x      = cur.tx;
      rect_y      = cur.top;
      rect_width  = {1'b0, cur.thick};
      rect_height = cur.arm;
    end else if (pend[2]) begin
      rect_x      = cur.mx;
      rect_y      = cur.ty;
      rect_width  = cur.arm;
      rect_height = {1'b0, cur.thick};
    end else if (pend[3]) begin
      rect_x      = cur.tx;
      rect_y      = cur.my;
      rect_width  = {1'b0, cur.thick};
      rect_height = cur.arm;
    end else if (pend[4]) begin
      rect_x      = cur.left;
      rect_y      = cur.ty;
      rect_width  = cur.arm;
      rect_height = {1'b0, cur.thick};
    end else begin
      rect_x      = cur.ix;
      rect_y      = cur.iy;
      rect_width  = {1'b0, cur.inner};
      rect_height = {1'b0, cur.inner};
      rect_rgb    = cur_hi;
    end
  end

endmodule

[hdl/pipe_cell_rect_generator_core.sv]
// Top level of the pipe cell rectangle generator.
// The path is six pipeline stages (three blend multiplies, geometry alongside) and the emitter.
// Throughput: one rectangle word per cycle while rect_ready is high; a cell issues one to six
// rectangle words, and cells with an empty mask are dropped at entry.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
module pipe_cell_rect_generator_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [23:0]            cfg_data,
  input  logic                   cell_valid,
  output logic                   cell_ready,
  input  logic [7:0]             cell_x,
  input  logic [7:0]             cell_y,
  input  logic [3:0]             conn_mask,
  input  logic [7:0]             glow_level,
  output logic                   rect_valid,
  input  logic                   rect_ready,
  output logic signed [17:0]     rect_x,
  output logic signed [17:0]     rect_y,
  output logic [7:0]             rect_width,
  output logic [7:0]             rect_height,
  output logic [23:0]            rect_rgb,
  output logic                   last_rect
);

  logic [23:0]        background_rgb;
  logic [23:0]        pipe_rgb;
  logic [23:0]        glow_rgb;
  logic [7:0]         tile_size;
  logic signed [14:0] origin_x;
  logic signed [14:0] origin_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      background_rgb <= pcrg_pkg::BACKGROUND_RESET;
      pipe_rgb       <= '0;
      glow_rgb       <= '0;
      tile_size      <= pcrg_pkg::TILE_SIZE_RESET;
      origin_x       <= '0;
      origin_y       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pcrg_pkg::REG_BACKGROUND: background_rgb <= cfg_data;
        pcrg_pkg::REG_PIPE:       pipe_rgb       <= cfg_data;
        pcrg_pkg::REG_GLOW:       glow_rgb       <= cfg_data;
        pcrg_pkg::REG_TILE_SIZE:  tile_size      <= cfg_data[7:0];
        pcrg_pkg::REG_ORIGIN_X:   origin_x       <= cfg_data[14:0];
        pcrg_pkg::REG_ORIGIN_Y:   origin_y       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic [6:1] v;
  logic [7:1] adv;
  logic       emit_ready;
  logic       keep;

  always_comb begin
    adv[7] = emit_ready;
    for (int i = 6; i >= 1; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign cell_ready = adv[1];
  assign keep = (conn_mask != 4'd0)
             && ({{(pcrg_pkg::GRID_W-8){1'b0}}, cell_x} < pcrg_pkg::GRID_W'(pcrg_pkg::GRID_SIDE))
             && ({{(pcrg_pkg::GRID_W-8){1'b0}}, cell_y} < pcrg_pkg::GRID_W'(pcrg_pkg::GRID_SIDE));

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) begin
        v[1] <= cell_valid && keep;
      end
      for (int i = 2; i <= 6; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  pcrg_pkg::cell_t c1, c2, c3, c4, c5, c6;
  pcrg_pkg::cell_t c1_next, c2_next, c3_next, c4_next, c5_next, c6_next;
  logic [15:0]     prod_third, prod_x, prod_y;
  logic [10:0]     glow_x7;
  logic [23:0]     base_rgb, active_rgb, hi_rgb;

  assign glow_x7 = {3'd0, glow_level} * 11'd7;

  always_comb begin
    c1_next       = '0;
    c1_next.mask  = conn_mask;
    c1_next.glow  = glow_level;
    c1_next.alpha = glow_x7[10:3];
    c1_next.cs    = tile_size;
  end

  always_comb begin
    c2_next       = c1;
    c2_next.thick = (prod_third[15:9] < pcrg_pkg::MIN_SIDE) ? pcrg_pkg::MIN_SIDE
                                                            : prod_third[15:9];
    c2_next.arm   = {1'b0, c1.cs[7:1]} + 8'd1;
    c2_next.left  = {{3{origin_x[14]}}, origin_x} + {2'b00, prod_x};
    c2_next.top   = {{3{origin_y[14]}}, origin_y} + {2'b00, prod_y};
  end

  always_comb begin
    logic [6:0] joint_raw;
    joint_raw     = c2.thick + 7'd2;
    c3_next       = c2;
    c3_next.joint = ({1'b0, joint_raw} > c2.cs) ? c2.cs[6:0] : joint_raw;
    c3_next.mx    = c2.left + {11'd0, c2.cs[7:1]};
    c3_next.my    = c2.top + {11'd0, c2.cs[7:1]};
  end

  always_comb begin
    c4_next       = c3;
    c4_next.inner = ({1'b0, c3.joint[6:1]} < pcrg_pkg::MIN_SIDE) ? pcrg_pkg::MIN_SIDE
                                                                 : {1'b0, c3.joint[6:1]};
    c4_next.jx    = c3.mx - {12'd0, c3.joint[6:1]};
    c4_next.jy    = c3.my - {12'd0, c3.joint[6:1]};
    c4_next.tx    = c3.mx - {12'd0, c3.thick[6:1]};
    c4_next.ty    = c3.my - {12'd0, c3.thick[6:1]};
  end

  always_comb begin
    c5_next        = c4;
    c5_next.ix     = c4.mx - {12'd0, c4.inner[6:1]};
    c5_next.iy     = c4.my - {12'd0, c4.inner[6:1]};
    c5_next.active = active_rgb;
  end

  assign c6_next = c5;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      c1         <= c1_next;
      prod_third <= {8'd0, tile_size} * {8'd0, pcrg_pkg::THIRD_RECIP};
      prod_x     <= {8'd0, cell_x} * {8'd0, tile_size};
      prod_y     <= {8'd0, cell_y} * {8'd0, tile_size};
    end
    if (adv[2]) begin
      c2 <= c2_next;
    end
    if (adv[3]) begin
      c3 <= c3_next;
    end
    if (adv[4]) begin
      c4 <= c4_next;
    end
    if (adv[5]) begin
      c5 <= c5_next;
    end
    if (adv[6]) begin
      c6 <= c6_next;
    end
  end

  pcrg_blend u_base (
    .clk    (clk),
    .en_mul (adv[1]),
    .en_sum (adv[2]),
    .lhs    (background_rgb),
    .rhs    (pipe_rgb),
    .alpha  (pcrg_pkg::PIPE_ALPHA),
    .rgb    (base_rgb)
  );

  pcrg_blend u_active (
    .clk    (clk),
    .en_mul (adv[3]),
    .en_sum (adv[4]),
    .lhs    (base_rgb),
    .rhs    (glow_rgb),
    .alpha  (c2.alpha),
    .rgb    (active_rgb)
  );

  pcrg_blend u_high (
    .clk    (clk),
    .en_mul (adv[5]),
    .en_sum (adv[6]),
    .lhs    (active_rgb),
    .rhs    (glow_rgb),
    .alpha  (pcrg_pkg::HIGHLIGHT_ALPHA),
    .rgb    (hi_rgb)
  );

  pcrg_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (v[6]),
    .load_ready  (emit_ready),
    .load_data   (c6),
    .hi_rgb      (hi_rgb),
    .rect_valid  (rect_valid),
    .rect_ready  (rect_ready),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .rect_rgb    (rect_rgb),
    .last_rect   (last_rect)
  );

endmodule

[hdl/pcrg_checker.sv]
// Port-level assertions for the rectangle generator and their bind.
module pcrg_checker (
  input logic               clk,
  input logic               rst,
  input logic               rect_valid,
  input logic               rect_ready,
  input logic signed [17:0] rect_x,
  input logic signed [17:0] rect_y,
  input logic [7:0]         rect_width,
  input logic [7:0]         rect_height,
  input logic [23:0]        rect_rgb,
  input logic               last_rect
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rect_valid && !rect_ready |=> rect_valid && $stable(rect_x) && $stable(rect_y)
      && $stable(rect_width) && $stable(rect_height) && $stable(rect_rgb)
      && $stable(last_rect))
    else $error("Stalled rectangle word changed or was dropped.");

  a_size: assert property (@(posedge clk) disable iff (rst)
    rect_valid |-> rect_width != 8'd0 && rect_height != 8'd0)
    else $error("Rectangle of zero size was issued.");

  a_reset: assert property (@(posedge clk)
    rst |=> !rect_valid)
    else $error("Rectangle word presented right after reset.");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    rect_valid && rect_ready && !last_rect |=> rect_valid)
    else $error("Cell ended without a final rectangle word.");

endmodule

bind pipe_cell_rect_generator_core pcrg_checker u_pcrg_checker (.*);
